// ----- src/kdta_pkg.sv -----
// shared types, constants and key map for the keypad scanner
`default_nettype none
package kdta_pkg;

    localparam int NUM_KEYS         = 16;
    localparam int KEY_W            = $clog2(NUM_KEYS);
    localparam int RUN_W            = 2;
    localparam int SLOT_W           = 5;
    localparam int BUFFER_DEPTH_DEF = 20;

    localparam logic [RUN_W-1:0] RUN_MAX = 2'd3;

    localparam logic OP_SCAN  = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    typedef struct packed {
        logic                opcode;
        logic [NUM_KEYS-1:0] raw_keys;
    } t_in_item;

    typedef struct packed {
        logic [7:0]        key_char;
        logic [SLOT_W-1:0] slot;
        logic              dropped;
        logic              last;
    } t_out_item;

    // one key result per cycle from the debounce pass to the emitter
    typedef struct packed {
        logic valid;
        logic fresh;
    } t_deb_bit;

    function automatic logic [7:0] key_ascii(input logic [KEY_W-1:0] idx);
        logic [7:0] ch;
        unique case (idx)
            4'd0:    ch = 8'h41; // A
            4'd1:    ch = 8'h42; // B
            4'd2:    ch = 8'h43; // C
            4'd3:    ch = 8'h44; // D
            4'd4:    ch = 8'h33; // 3
            4'd5:    ch = 8'h36; // 6
            4'd6:    ch = 8'h39; // 9
            4'd7:    ch = 8'h23; // #
            4'd8:    ch = 8'h32; // 2
            4'd9:    ch = 8'h35; // 5
            4'd10:   ch = 8'h38; // 8
            4'd11:   ch = 8'h30; // 0
            4'd12:   ch = 8'h31; // 1
            4'd13:   ch = 8'h34; // 4
            4'd14:   ch = 8'h37; // 7
            default: ch = 8'h2A; // *
        endcase
        return ch;
    endfunction

endpackage
`default_nettype wire

// ----- src/kdta_debounce.sv -----
// serial debounce pass: one key per cycle through rotating press counts
`default_nettype none
module kdta_debounce (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_start,
    input  wire logic [kdta_pkg::NUM_KEYS-1:0] i_pressed,
    output kdta_pkg::t_deb_bit            o_bit,
    output logic                          o_busy
);
    import kdta_pkg::*;

    logic [RUN_W-1:0]    r_run [NUM_KEYS];
    logic [NUM_KEYS-1:0] r_held;
    logic [NUM_KEYS-1:0] r_press;
    logic [KEY_W-1:0]    r_cnt;
    logic                r_busy;

    logic [RUN_W-1:0] n_run;
    logic             clicked;

    always_comb begin
        if (!r_press[0]) begin
            n_run = '0;
        end else if (r_run[0] == RUN_MAX) begin
            n_run = RUN_MAX;
        end else begin
            n_run = RUN_W'(r_run[0] + 1'b1);
        end
    end

    // held once the count passes one
    assign clicked = n_run[RUN_W-1];

    assign o_bit.valid = r_busy;
    assign o_bit.fresh = clicked & ~r_held[0];
    assign o_busy      = r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_held <= '0;
            for (int i = 0; i < NUM_KEYS; i++) begin
                r_run[i] <= '0;
            end
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            // key 0 sits at the head, updated value rejoins at the tail
            for (int i = 0; i < NUM_KEYS - 1; i++) begin
                r_run[i] <= r_run[i+1];
            end
            r_run[NUM_KEYS-1] <= n_run;
            r_held            <= {clicked, r_held[NUM_KEYS-1:1]};
            r_cnt             <= KEY_W'(r_cnt + 1'b1);
            if (r_cnt == KEY_W'(NUM_KEYS - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_press <= i_pressed;
        end else if (r_busy) begin
            r_press <= {1'b0, r_press[NUM_KEYS-1:1]};
        end
    end

endmodule
`default_nettype wire

// ----- src/kdta_emit.sv -----
// collects new-key flags, walks them and emits characters with buffer slots
`default_nettype none
module kdta_emit #(
    parameter int BUFFER_DEPTH = kdta_pkg::BUFFER_DEPTH_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire kdta_pkg::t_deb_bit  i_bit,
    input  wire logic                i_clear,
    output logic                     o_busy,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output kdta_pkg::t_out_item      o_out_item
);
    import kdta_pkg::*;

    localparam int FILL_W = $clog2(BUFFER_DEPTH + 1);

    typedef enum logic {
        E_COLLECT,
        E_EMIT
    } t_emit_state;

    t_emit_state         r_state,     n_state;
    logic [NUM_KEYS-1:0] r_fresh,     n_fresh;
    logic [KEY_W-1:0]    r_key,       n_key;
    logic [FILL_W-1:0]   r_fill,      n_fill;
    logic                r_out_valid, n_out_valid;
    t_out_item           r_out,       n_out;

    logic can_load;

    assign can_load = ~r_out_valid | i_out_ready;

    always_comb begin
        n_state     = r_state;
        n_fresh     = r_fresh;
        n_key       = r_key;
        n_fill      = r_fill;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (i_clear) begin
            n_fill = '0;
        end
        unique case (r_state)
            E_COLLECT: begin
                if (i_bit.valid) begin
                    n_fresh = {i_bit.fresh, r_fresh[NUM_KEYS-1:1]};
                    if (r_key == KEY_W'(NUM_KEYS - 1)) begin
                        n_state = E_EMIT;
                        n_key   = '0;
                    end else begin
                        n_key = KEY_W'(r_key + 1'b1);
                    end
                end
            end
            E_EMIT: begin
                if (r_fresh == '0) begin
                    n_state = E_COLLECT;
                    n_key   = '0;
                end else if (!r_fresh[0] || can_load) begin
                    n_fresh = {1'b0, r_fresh[NUM_KEYS-1:1]};
                    n_key   = KEY_W'(r_key + 1'b1);
                    if (r_fresh[0]) begin
                        n_out_valid    = 1'b1;
                        n_out.key_char = key_ascii(r_key);
                        n_out.last     = (r_fresh[NUM_KEYS-1:1] == '0);
                        if (r_fill < FILL_W'(BUFFER_DEPTH)) begin
                            n_out.slot    = SLOT_W'(r_fill);
                            n_out.dropped = 1'b0;
                            n_fill        = FILL_W'(r_fill + 1'b1);
                        end else begin
                            n_out.slot    = '0;
                            n_out.dropped = 1'b1;
                        end
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= E_COLLECT;
            r_key       <= '0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_key       <= n_key;
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
        end
        r_fresh <= n_fresh;
        r_out   <= n_out;
    end

    assign o_busy      = (r_state == E_EMIT);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule
`default_nettype wire

// ----- src/keypad_debounce_to_ascii_unit.sv -----
// 4x4 keypad scanner: debounce, new-key detection, ascii mapping, buffer slots
//
// input channel i_in_valid / o_in_ready carries one item: opcode and raw_keys.
// a scan item (active-low key bits, column 0 in the top nibble) first runs a
// debounce pass that updates one key per cycle from a rotating line of press
// counts. a second pass then walks the new-key flags one key index per cycle
// while the output register can take a character, and loads each character
// into the output register. a scan item occupies the block through both
// passes, until the serial key walk is past the highest new key. a clear item
// emits nothing.
// output channel o_out_valid / i_out_ready: one item per character, last set on
// the final one of a scan. the output register lets the next item be accepted
// while a result waits; a stalled receiver holds the key walk at the next new
// key until the register frees.
// reset clears press counts, held keys, buffer fill and the output valid flag.
`default_nettype none
module keypad_debounce_to_ascii_unit #(
    parameter int BUFFER_DEPTH = kdta_pkg::BUFFER_DEPTH_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire kdta_pkg::t_in_item  i_in_item,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output kdta_pkg::t_out_item      o_out_item
);
    import kdta_pkg::*;

    logic     in_accept;
    logic     scan_start;
    logic     clear_req;
    logic     deb_busy;
    logic     emit_busy;
    t_deb_bit deb_bit;

    assign o_in_ready = ~deb_busy & ~emit_busy;
    assign in_accept  = i_in_valid & o_in_ready;
    assign scan_start = in_accept & (i_in_item.opcode == OP_SCAN);
    assign clear_req  = in_accept & (i_in_item.opcode == OP_CLEAR);

    kdta_debounce u_debounce (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (scan_start),
        .i_pressed (~i_in_item.raw_keys),
        .o_bit     (deb_bit),
        .o_busy    (deb_busy)
    );

    kdta_emit #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_bit       (deb_bit),
        .i_clear     (clear_req),
        .o_busy      (emit_busy),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

`ifndef SYNTH
    a_scan_starts_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        scan_start |=> deb_busy)
        else $error("accepted scan did not start the debounce pass");

    a_passes_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(deb_busy && emit_busy))
        else $error("debounce pass and key walk overlap");

    a_dropped_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.dropped) |-> (o_out_item.slot == '0))
        else $error("dropped character carries a nonzero slot");
`endif

endmodule
`default_nettype wire

// ----- bench/keypad_debounce_to_ascii_unit_test.sv -----
// self-checking bench for the keypad scanner: directed table, random key sequences, handshake stress
`timescale 1ns / 100ps
module keypad_debounce_to_ascii_unit_test;
    import kdta_pkg::*;

    localparam int BUF_DEPTH      = BUFFER_DEPTH_DEF;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int LONG_HOLD      = 400;
    localparam int RANDOM_PER_PHASE = 96;
    // keypad face, row by row, column 0 on the left
    localparam logic [127:0] KEYPAD_ROWS = "123A456B789C*0#D";

    typedef struct packed {
        t_in_item  item;
        logic      typed;
        logic      has_res;
        t_out_item res;
    } t_step_row;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_ready;
    t_in_item  i_in_item = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_item o_out_item;

    // debounce state mirrored from the block
    logic [RUN_W-1:0]    run_cnt [NUM_KEYS];
    logic [NUM_KEYS-1:0] held_keys;
    int                  fill_cnt;

    t_out_item pending_chars [$];
    t_step_row steps [$];
    t_out_item want;

    int send_idle_pct = 9;
    int recv_stall_pct = 74;
    logic hold_req = 1'b0;
    logic hold_taken = 1'b0;
    int hold_left = 0;

    int bad = 0;
    int stall_cycles = 0;
    int items_sent = 0;
    int clears_sent = 0;
    int chars_seen = 0;
    int drops_seen = 0;

    always #6 i_clk = ~i_clk;

    keypad_debounce_to_ascii_unit #(
        .BUFFER_DEPTH(BUF_DEPTH)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_in_item(i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_item(o_out_item)
    );

    function automatic logic [7:0] char_of_key(input int idx);
        int pos;
        // key index runs down a column; column 0 sits in the top nibble
        pos = (idx % 4) * 4 + (3 - idx / 4);
        return KEYPAD_ROWS[127 - 8 * pos -: 8];
    endfunction

    function automatic t_step_row step_row(input logic op, input logic [15:0] keys,
                                           input logic typed, input logic has_res,
                                           input logic [7:0] ch, input logic [4:0] slot,
                                           input logic drop);
        t_step_row r;
        r.item.opcode   = op;
        r.item.raw_keys = keys;
        r.typed         = typed;
        r.has_res       = has_res;
        r.res.key_char  = ch;
        r.res.slot      = slot;
        r.res.dropped   = drop;
        r.res.last      = 1'b1;
        return r;
    endfunction

    task automatic debounce_scan(input t_in_item it, input bit enqueue);
        logic [NUM_KEYS-1:0] down;
        logic [NUM_KEYS-1:0] now_held;
        logic [NUM_KEYS-1:0] fresh;
        t_out_item           r;
        int                  last_idx;
        if (it.opcode == OP_CLEAR) begin
            fill_cnt = 0;
        end else begin
            down     = ~it.raw_keys;
            now_held = '0;
            for (int i = 0; i < NUM_KEYS; i++) begin
                if (down[i]) begin
                    if (run_cnt[i] != RUN_MAX) run_cnt[i] = run_cnt[i] + 1'b1;
                    if (run_cnt[i] > 1) now_held[i] = 1'b1;
                end else begin
                    run_cnt[i] = '0;
                end
            end
            fresh     = now_held & ~held_keys;
            held_keys = now_held;
            last_idx  = -1;
            for (int i = 0; i < NUM_KEYS; i++) begin
                if (fresh[i]) last_idx = i;
            end
            for (int i = 0; i < NUM_KEYS; i++) begin
                if (fresh[i]) begin
                    r.key_char = char_of_key(i);
                    if (fill_cnt < BUF_DEPTH) begin
                        r.slot    = fill_cnt[SLOT_W-1:0];
                        r.dropped = 1'b0;
                        fill_cnt++;
                    end else begin
                        r.slot    = '0;
                        r.dropped = 1'b1;
                    end
                    r.last = (i == last_idx);
                    if (enqueue) pending_chars.push_back(r);
                end
            end
        end
    endtask

    task automatic offer_item(input t_in_item it);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        items_sent++;
        if (it.opcode == OP_CLEAR) clears_sent++;
    endtask

    task automatic offer_and_predict(input logic op, input logic [15:0] keys);
        t_in_item it;
        it.opcode   = op;
        it.raw_keys = keys;
        offer_item(it);
        debounce_scan(it, 1'b1);
    endtask

    // sender pauses until every expected character has come out
    task automatic wait_chars_out();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_chars.size() != 0);
    endtask

    task automatic flag_error(input string msg);
        bad++;
        if (bad <= 10) $display("%s", msg);
    endtask

    // receiver: random stalls, plus one long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            i_out_ready <= 1'b0;
            hold_left   <= hold_left - 1;
        end else if (hold_req && !hold_taken) begin
            hold_taken  <= 1'b1;
            hold_left   <= LONG_HOLD;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            chars_seen++;
            if (o_out_item.dropped) drops_seen++;
            if (pending_chars.size() == 0) begin
                flag_error($sformatf("unexpected item: char %h slot %0d drop %0b last %0b",
                                     o_out_item.key_char, o_out_item.slot,
                                     o_out_item.dropped, o_out_item.last));
            end else begin
                want = pending_chars.pop_front();
                if (o_out_item.key_char !== want.key_char || o_out_item.slot !== want.slot ||
                    o_out_item.dropped !== want.dropped || o_out_item.last !== want.last) begin
                    flag_error($sformatf({"mismatch: got char %h slot %0d drop %0b last %0b,",
                                          " want char %h slot %0d drop %0b last %0b"},
                                         o_out_item.key_char, o_out_item.slot,
                                         o_out_item.dropped, o_out_item.last,
                                         want.key_char, want.slot, want.dropped, want.last));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles == WATCHDOG_LIMIT) begin
            $display("timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        int               roll;
        int               n;
        int               reps;
        logic [15:0]      pattern;

        for (int i = 0; i < NUM_KEYS; i++) run_cnt[i] = '0;
        held_keys = '0;
        fill_cnt  = 0;

        // key bits are active low: 0xFFFF is no key down
        steps.push_back(step_row(OP_SCAN,  16'hFFFF, 1, 0, 8'h00, 5'd0, 0));
        steps.push_back(step_row(OP_SCAN,  16'hFFFE, 1, 0, 8'h00, 5'd0, 0));
        steps.push_back(step_row(OP_SCAN,  16'hFFFE, 1, 1, "A",   5'd0, 0));
        steps.push_back(step_row(OP_SCAN,  16'hFFFE, 1, 0, 8'h00, 5'd0, 0));
        steps.push_back(step_row(OP_SCAN,  16'hFFFE, 1, 0, 8'h00, 5'd0, 0)); // count saturated
        steps.push_back(step_row(OP_CLEAR, 16'h0000, 1, 0, 8'h00, 5'd0, 0));
        steps.push_back(step_row(OP_SCAN,  16'h7FFF, 1, 0, 8'h00, 5'd0, 0));
        steps.push_back(step_row(OP_SCAN,  16'h7FFF, 1, 1, "*",   5'd0, 0));
        steps.push_back(step_row(OP_SCAN,  16'h0000, 1, 0, 8'h00, 5'd0, 0));
        steps.push_back(step_row(OP_SCAN,  16'h0000, 0, 0, 8'h00, 5'd0, 0));
        steps.push_back(step_row(OP_SCAN,  16'hFFFF, 1, 0, 8'h00, 5'd0, 0));
        steps.push_back(step_row(OP_SCAN,  16'h0000, 1, 0, 8'h00, 5'd0, 0));
        // all sixteen at once: fills the last slots, the rest drop
        steps.push_back(step_row(OP_SCAN,  16'h0000, 0, 0, 8'h00, 5'd0, 0));
        steps.push_back(step_row(OP_SCAN,  16'hFFFF, 1, 0, 8'h00, 5'd0, 0));
        steps.push_back(step_row(OP_SCAN,  16'hFFFD, 1, 0, 8'h00, 5'd0, 0));
        steps.push_back(step_row(OP_SCAN,  16'hFFFD, 1, 1, "B",   5'd0, 1));
        steps.push_back(step_row(OP_CLEAR, 16'hFFFF, 1, 0, 8'h00, 5'd0, 0));
        steps.push_back(step_row(OP_SCAN,  16'hFFFD, 1, 0, 8'h00, 5'd0, 0)); // still held
        steps.push_back(step_row(OP_SCAN,  16'h5A5A, 1, 0, 8'h00, 5'd0, 0));
        steps.push_back(step_row(OP_SCAN,  16'h5A5A, 0, 0, 8'h00, 5'd0, 0));
        steps.push_back(step_row(OP_SCAN,  16'hA5A5, 1, 0, 8'h00, 5'd0, 0));
        steps.push_back(step_row(OP_SCAN,  16'hA5A5, 0, 0, 8'h00, 5'd0, 0));
        steps.push_back(step_row(OP_CLEAR, 16'h0000, 1, 0, 8'h00, 5'd0, 0));

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (steps[k]) begin
            offer_item(steps[k].item);
            if (steps[k].typed) begin
                debounce_scan(steps[k].item, 1'b0);
                if (steps[k].has_res) pending_chars.push_back(steps[k].res);
            end else begin
                debounce_scan(steps[k].item, 1'b1);
            end
        end
        wait_chars_out();

        for (int p = 0; p < 3; p++) begin
            case (p)
                0: begin
                    send_idle_pct  = 9;
                    recv_stall_pct <= 74;
                end
                1: begin
                    send_idle_pct  = 74;
                    recv_stall_pct <= 9;
                end
                default: begin
                    send_idle_pct  = 0;
                    recv_stall_pct <= 0;
                    // long receiver hold-off while items keep coming
                    hold_req <= 1'b1;
                end
            endcase
            n = 0;
            while (n < RANDOM_PER_PHASE) begin
                roll = $urandom_range(0, 99);
                if (roll < 8) begin
                    offer_and_predict(OP_CLEAR, 16'($urandom_range(0, 65535)));
                    n++;
                end else if (roll < 18) begin
                    // noise: one stray scan or a full release
                    pattern = ($urandom_range(0, 1) != 0) ? 16'hFFFF
                                                          : 16'($urandom_range(0, 65535));
                    offer_and_predict(OP_SCAN, pattern);
                    n++;
                end else begin
                    if ($urandom_range(0, 3) == 0) begin
                        pattern = 16'($urandom_range(0, 65535));
                    end else begin
                        pattern = '0;
                        repeat ($urandom_range(1, 3)) pattern[$urandom_range(0, 15)] = 1'b1;
                    end
                    // one repeat is a bounce that never reaches held
                    reps = $urandom_range(1, 4);
                    repeat (reps) offer_and_predict(OP_SCAN, ~pattern);
                    n += reps;
                end
            end
            wait_chars_out();
        end

        repeat (60) @(posedge i_clk);
        $display("%0d items sent (%0d clears), %0d characters checked, %0d dropped on full buffer",
                 items_sent, clears_sent, chars_seen, drops_seen);
        $display("three idle patterns plus a %0d-cycle receiver hold; %0d mismatches",
                 LONG_HOLD, bad);
        if (bad == 0 && pending_chars.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ----- keypad_debounce_to_ascii_unit.f -----
src/kdta_pkg.sv
src/kdta_debounce.sv
src/kdta_emit.sv
src/keypad_debounce_to_ascii_unit.sv
bench/keypad_debounce_to_ascii_unit_test.sv
